### rtl/core/vrg_pkg.sv
// Shared definitions for the velocity ramp generator.
// Widths, action codes, register indexes and the time ceiling.
// No dependencies.
package vrg_pkg;

    localparam int TIME_W = 48;
    localparam int VEL_W  = 32;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_TARGET = 2'd1;
    localparam logic [1:0] ACT_STOP   = 2'd2;

    localparam logic [IDX_W-1:0] REG_VEL_LIMIT   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ACCEL       = 3'd1;
    localparam logic [IDX_W-1:0] REG_DECEL       = 3'd2;
    localparam logic [IDX_W-1:0] REG_QUICK_DECEL = 3'd3;
    localparam logic [IDX_W-1:0] REG_TICKS       = 3'd4;
    localparam logic [IDX_W-1:0] REG_POLARITY    = 3'd5;

endpackage

### rtl/core/velocity_ramp_generator.sv
// Velocity ramp generator: top level, sequencer and shared datapath.
// Depends on vrg_pkg.
//
// The input is not ready while a word is in work. A sample
// (action 0) skips the interpolation loop when the demand lies on a ramp end; else the loop doubles
// and reduces, then adds and reduces, for each bit of a 34-bit magnitude through the shared
// compare-subtract unit. A new target or stop ramp (actions 1 and 2) adds an interpolation, the
// planning states PLAN and JOB, and one or two duration jobs (none on a null-rate fault), each a
// shift-add multiply by ticks_per_second, a restoring division by the rate and a saturating add.
// A finished result waits in an output register; the next word is taken while it waits, and the
// block stalls only when a second result is ready before the first is taken.
module velocity_ramp_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_action,
    input  logic [vrg_pkg::TIME_W-1:0]  s_sample_time,
    input  logic signed [vrg_pkg::VEL_W-1:0] s_new_velocity,
    input  logic                        s_min_limit_active,
    input  logic                        s_max_limit_active,
    input  logic                        s_quick_stop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [vrg_pkg::VEL_W-1:0] m_speed_demand,
    output logic                        m_accelerating,
    output logic                        m_null_rate_fault,
    input  logic                        cfg_we,
    input  logic [vrg_pkg::IDX_W-1:0]   cfg_index,
    input  logic [vrg_pkg::CFG_W-1:0]   cfg_wdata
);
    import vrg_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SETUP = 4'd1;
    localparam logic [3:0] ST_DIFF  = 4'd2;
    localparam logic [3:0] ST_SCALE = 4'd3;
    localparam logic [3:0] ST_FIN   = 4'd4;
    localparam logic [3:0] ST_PLAN  = 4'd5;
    localparam logic [3:0] ST_JOB   = 4'd6;
    localparam logic [3:0] ST_MUL   = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_TADD  = 4'd9;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    // configuration
    logic [30:0] vel_limit_reg;
    logic [31:0] accel_reg, decel_reg, quick_reg;
    logic [29:0] ticks_reg;
    logic        pol_inv_reg;

    // ramp state
    logic signed [31:0] start_vel_reg, goal_reg;
    logic [TIME_W-1:0]  start_time_reg, rev_reg, fin_reg;

    // current word
    logic [3:0]         state_reg;
    logic               final_reg;
    logic [1:0]         act_reg;
    logic [TIME_W-1:0]  t_reg;
    logic signed [31:0] req_reg;
    logic               lmin_reg, lmax_reg, qstop_reg, fault_reg;
    logic signed [31:0] vel_reg;

    // interpolation
    logic               direct_reg, acc_reg, neg_reg, phase_reg;
    logic signed [31:0] dval_reg, from_reg, to_reg;
    logic [TIME_W-1:0]  num_reg, den_reg, r_reg;
    logic [33:0]        sc_a_reg, q_reg;
    logic [5:0]         cnt_reg;

    // duration job
    logic [31:0]        rate_reg, rem_reg;
    logic [TIME_W-1:0]  base_reg;
    logic               dest_rev_reg, second_reg;
    logic [62:0]        mcand_reg, prod_reg;
    logic [29:0]        mplier_reg;

    // output
    logic               m_valid_reg;
    logic signed [31:0] m_dem_reg;
    logic               m_acc_reg, m_fault_reg;

    // shared compare-subtract unit
    logic [49:0] cs_in, cs_out;
    logic [47:0] cs_div;
    logic        cs_ge;

    always_comb begin
        unique case (state_reg)
            ST_DIV: begin
                cs_in  = {17'd0, rem_reg, prod_reg[62]};
                cs_div = {16'd0, rate_reg};
            end
            ST_SCALE: begin
                if (!phase_reg) begin
                    cs_in = {1'b0, r_reg, 1'b0};
                end else begin
                    cs_in = {2'b0, r_reg} + (sc_a_reg[33] ? {2'b0, num_reg} : 50'd0);
                end
                cs_div = den_reg;
            end
            default: begin
                cs_in  = 50'd0;
                cs_div = den_reg;
            end
        endcase
        cs_ge  = cs_in >= {2'b0, cs_div};
        cs_out = cs_ge ? cs_in - {2'b0, cs_div} : cs_in;
    end

    // sample setup: pick the phase of the ramp that holds t
    logic              t_gt_fin, t_lt_rev, rev_none;
    logic [TIME_W-1:0] el;
    always_comb begin
        t_gt_fin = t_reg > fin_reg;
        t_lt_rev = t_reg < rev_reg;
        rev_none = rev_reg == '0;
        el       = (t_reg > start_time_reg) ? t_reg - start_time_reg : '0;
    end

    // interpolation diff and finish
    logic signed [32:0] diff;
    logic [33:0]        fin_sum;
    logic signed [31:0] fin_val;
    always_comb begin
        diff    = {to_reg[31], to_reg} - {from_reg[31], from_reg};
        fin_sum = neg_reg ? {{2{from_reg[31]}}, from_reg} - q_reg
                          : {{2{from_reg[31]}}, from_reg} + q_reg;
        fin_val = direct_reg ? dval_reg : fin_sum[31:0];
    end

    // target clamp
    logic signed [31:0] lim_pos, lim_neg, goal_clamped;
    logic               rate_fault;
    always_comb begin
        lim_pos = {1'b0, vel_limit_reg};
        lim_neg = -lim_pos;
        if (!pol_inv_reg) begin
            if (lmin_reg) lim_neg = '0;
            if (lmax_reg) lim_pos = '0;
        end else begin
            if (lmin_reg) lim_pos = '0;
            if (lmax_reg) lim_neg = '0;
        end
        if (!req_reg[31]) begin
            goal_clamped = (req_reg < lim_pos) ? req_reg : lim_pos;
        end else begin
            goal_clamped = (req_reg > lim_neg) ? req_reg : lim_neg;
        end
        if (act_reg == ACT_STOP) begin
            rate_fault = decel_reg == '0;
        end else begin
            rate_fault = accel_reg == '0 || decel_reg == '0 || quick_reg == '0;
        end
    end

    logic signed [32:0] goal_minus_vel;
    logic [32:0]        gv_mag;
    logic               reverse;
    logic [63:0]        tsum;
    logic [TIME_W-1:0]  tsat;
    always_comb begin
        goal_minus_vel = {goal_reg[31], goal_reg} - {vel_reg[31], vel_reg};
        gv_mag  = goal_minus_vel[32] ? 33'(-goal_minus_vel) : 33'(goal_minus_vel);
        reverse = (!vel_reg[31] && goal_reg[31]) || (vel_reg[31] && goal_reg > 0);
        tsum    = {16'd0, base_reg} + {1'b0, prod_reg};
        tsat    = (tsum[63:TIME_W] != '0) ? TIME_MAX : tsum[TIME_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_limit_reg <= '0;
            accel_reg     <= 32'd1000;
            decel_reg     <= 32'd1000;
            quick_reg     <= 32'd1000;
            ticks_reg     <= 30'd1000000;
            pol_inv_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_VEL_LIMIT:   vel_limit_reg <= cfg_wdata[30:0];
                REG_ACCEL:       accel_reg     <= cfg_wdata;
                REG_DECEL:       decel_reg     <= cfg_wdata;
                REG_QUICK_DECEL: quick_reg     <= cfg_wdata;
                REG_TICKS:       ticks_reg     <= cfg_wdata[29:0];
                REG_POLARITY:    pol_inv_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            start_vel_reg  <= '0;
            goal_reg       <= '0;
            start_time_reg <= '0;
            rev_reg        <= '0;
            fin_reg        <= '0;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        act_reg   <= s_action;
                        t_reg     <= s_sample_time;
                        req_reg   <= s_new_velocity;
                        lmin_reg  <= s_min_limit_active;
                        lmax_reg  <= s_max_limit_active;
                        qstop_reg <= s_quick_stop;
                        fault_reg <= 1'b0;
                        final_reg <= !(s_action == ACT_TARGET || s_action == ACT_STOP);
                        state_reg <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    direct_reg <= 1'b0;
                    dval_reg   <= goal_reg;
                    from_reg   <= start_vel_reg;
                    to_reg     <= goal_reg;
                    num_reg    <= el;
                    den_reg    <= fin_reg - start_time_reg;
                    if (t_gt_fin) begin
                        acc_reg    <= 1'b0;
                        direct_reg <= 1'b1;
                    end else if (rev_none) begin
                        acc_reg    <= abs32(goal_reg) > abs32(start_vel_reg);
                        direct_reg <= fin_reg <= start_time_reg;
                    end else if (t_lt_rev) begin
                        acc_reg    <= 1'b0;
                        dval_reg   <= '0;
                        to_reg     <= '0;
                        den_reg    <= rev_reg - start_time_reg;
                        direct_reg <= rev_reg <= start_time_reg;
                    end else begin
                        acc_reg    <= 1'b1;
                        from_reg   <= '0;
                        num_reg    <= t_reg - rev_reg;
                        den_reg    <= fin_reg - rev_reg;
                        direct_reg <= fin_reg <= rev_reg;
                    end
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    neg_reg   <= diff[32];
                    sc_a_reg  <= {1'b0, (diff[32] ? 33'(-diff) : 33'(diff))};
                    r_reg     <= '0;
                    q_reg     <= '0;
                    phase_reg <= 1'b0;
                    cnt_reg   <= 6'd34;
                    state_reg <= direct_reg ? ST_FIN : ST_SCALE;
                end
                ST_SCALE: begin
                    // double, reduce; then add num for a set bit, reduce
                    r_reg     <= cs_out[TIME_W-1:0];
                    phase_reg <= !phase_reg;
                    if (!phase_reg) begin
                        q_reg <= {q_reg[32:0], cs_ge};
                    end else begin
                        q_reg    <= q_reg + {33'd0, cs_ge};
                        sc_a_reg <= {sc_a_reg[32:0], 1'b0};
                        cnt_reg  <= cnt_reg - 6'd1;
                        if (cnt_reg == 6'd1) state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!final_reg) begin
                        vel_reg   <= fin_val;
                        state_reg <= ST_PLAN;
                    end else if (!m_valid_reg || m_ready) begin
                        m_dem_reg   <= fin_val;
                        m_acc_reg   <= acc_reg;
                        m_fault_reg <= fault_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                ST_PLAN: begin
                    start_vel_reg  <= vel_reg;
                    start_time_reg <= t_reg;
                    rev_reg        <= '0;
                    goal_reg       <= (act_reg == ACT_STOP) ? 32'sd0 : goal_clamped;
                    fault_reg      <= rate_fault;
                    state_reg      <= ST_JOB;
                end
                ST_JOB: begin
                    base_reg     <= t_reg;
                    dest_rev_reg <= 1'b0;
                    second_reg   <= 1'b0;
                    mcand_reg    <= {30'd0, 1'b0, abs32(vel_reg)};
                    mplier_reg   <= ticks_reg;
                    prod_reg     <= '0;
                    cnt_reg      <= 6'd30;
                    state_reg    <= ST_MUL;
                    if (fault_reg) begin
                        fin_reg   <= t_reg;
                        final_reg <= 1'b1;
                        state_reg <= ST_SETUP;
                    end else if (act_reg == ACT_STOP) begin
                        rate_reg <= decel_reg;
                    end else if (qstop_reg) begin
                        rate_reg <= quick_reg;
                    end else if (reverse) begin
                        rate_reg     <= decel_reg;
                        dest_rev_reg <= 1'b1;
                        second_reg   <= 1'b1;
                    end else begin
                        mcand_reg <= {30'd0, gv_mag};
                        rate_reg  <= (abs32(goal_reg) >= abs32(vel_reg)) ? accel_reg : decel_reg;
                    end
                end
                ST_MUL: begin
                    if (mplier_reg[0]) prod_reg <= prod_reg + mcand_reg;
                    mcand_reg  <= {mcand_reg[61:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[29:1]};
                    cnt_reg    <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) begin
                        rem_reg   <= '0;
                        cnt_reg   <= 6'd63;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    // quotient bits shift in as dividend bits shift out
                    rem_reg  <= cs_out[31:0];
                    prod_reg <= {prod_reg[61:0], cs_ge};
                    cnt_reg  <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1) state_reg <= ST_TADD;
                end
                ST_TADD: begin
                    if (dest_rev_reg) begin
                        rev_reg <= tsat;
                    end else begin
                        fin_reg <= tsat;
                    end
                    if (second_reg) begin
                        base_reg     <= tsat;
                        mcand_reg    <= {31'd0, abs32(goal_reg)};
                        mplier_reg   <= ticks_reg;
                        prod_reg     <= '0;
                        rate_reg     <= accel_reg;
                        dest_rev_reg <= 1'b0;
                        second_reg   <= 1'b0;
                        cnt_reg      <= 6'd30;
                        state_reg    <= ST_MUL;
                    end else begin
                        final_reg <= 1'b1;
                        state_reg <= ST_SETUP;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_speed_demand    = m_dem_reg;
    assign m_accelerating    = m_acc_reg;
    assign m_null_rate_fault = m_fault_reg;

endmodule

### rtl/core/vrg_checker.sv
// Port-level checks for the velocity ramp generator.
// Depends on vrg_pkg; bound to velocity_ramp_generator below.
module vrg_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic signed [vrg_pkg::VEL_W-1:0] m_speed_demand,
    input logic                        m_accelerating,
    input logic                        m_null_rate_fault
);

    // busy after taking a word
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready straight after accepting a word");

    // no result appears the cycle after a word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result raised too early");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_speed_demand)
            && $stable(m_accelerating) && $stable(m_null_rate_fault))
        else $error("stalled result changed");

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind velocity_ramp_generator vrg_checker u_vrg_checker (.*);
